>>> src/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BLOCKS_DEF  = 256;
  localparam int BLOCK_BYTES_DEF = 64;

  // Field widths fixed by the item format
  localparam int SIZE_W  = 15;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLAIM = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD     = 3'd1;
  localparam logic [STAT_W-1:0] ST_SHORT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NORUN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_USED    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTUSED = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SIZE_W-1:0]  size_bytes;
    logic [INDEX_W-1:0] block_index;
    logic [COUNT_W-1:0] block_count;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] start_block;
    logic [COUNT_W-1:0] free_blocks;
    logic [COUNT_W-1:0] largest_free_run;
  } out_item_t;

endpackage

>>> src/ffba_run_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_run_track
// Serial longest-free-run tracker, fed one bitmap bit per cycle while en is high.
// ----------------------------------------------------------------------------
module ffba_run_track #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          en,
  input  logic                          free_bit,
  output logic [$clog2(NUM_BLOCKS+1)-1:0] best
);

  localparam int CW = $clog2(NUM_BLOCKS + 1);

  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [CW-1:0] run_inc;

  always_comb begin
    run_inc  = run_r + CW'(1);
    run_nxt  = run_r;
    best_nxt = best_r;
    if (clr) begin
      run_nxt  = '0;
      best_nxt = '0;
    end else if (en) begin
      if (free_bit) begin
        run_nxt = run_inc;
        if (run_inc > best_r) best_nxt = run_inc;
      end else begin
        run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      best_r <= '0;
    end else begin
      run_r  <= run_nxt;
      best_r <= best_nxt;
    end
  end

  assign best = best_r;

endmodule

>>> src/first_fit_block_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_bitmap_allocator_top
// First-fit allocator over a used/free bitmap with a free-block counter.
// ----------------------------------------------------------------------------
// One command is worked at a time. The bitmap sits in a circular shift
// register that rotates one block per cycle past a single read/modify point
// while a command is in its find or scan pass, so every command costs whole
// rotations. Free, free range, claim, clear, zero-size allocate and undefined
// codes take one rotation before they raise their result; an allocate that
// fails the free-space check passes a check state before that rotation, and
// any other allocate takes a check state and two rotations (one to find the
// first fitting run, one to mark it and measure the longest free run). The
// block then returns to idle, where it can accept the next item. The result
// sits in an output register, so the next item is accepted as soon as the
// block is idle, even while the last result waits.
// ----------------------------------------------------------------------------
module first_fit_block_bitmap_allocator_top #(
  parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_item_t out_data
);

  localparam int PW  = $clog2(NUM_BLOCKS);
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam int BBW = $clog2(BLOCK_BYTES + 1);
  localparam int PRW = CW + BBW;
  localparam int BW  = $clog2((2 ** ffba_pkg::SIZE_W) + BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FIND,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [NUM_BLOCKS-1:0]           bm_r, bm_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [CW-1:0]                   free_r, free_nxt;
  logic [ffba_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [ffba_pkg::SIZE_W-1:0]     size_r, size_nxt;
  logic [ffba_pkg::INDEX_W-1:0]    idx_r, idx_nxt;
  logic [ffba_pkg::COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ffba_pkg::STAT_W-1:0]     status_r, status_nxt;
  logic [PW-1:0]                   start_r, start_nxt;
  logic [PW-1:0]                   run_start_r, run_start_nxt;
  logic [BW-1:0]                   cur_bytes_r, cur_bytes_nxt;
  logic [BW-1:0]                   mark_bytes_r, mark_bytes_nxt;
  logic                            found_r, found_nxt;
  logic [PRW-1:0]                  prod_r, prod_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ffba_pkg::out_item_t             out_data_r, out_data_nxt;

  logic                            tr_clr, tr_en, tr_free;
  logic [CW-1:0]                   best;
  logic                            head, new_b, last_pos, at_idx, in_range;
  logic [BW-1:0]                   cur_sum;

  ffba_run_track #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_run_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (tr_clr),
    .en       (tr_en),
    .free_bit (tr_free),
    .best     (best)
  );

  assign head     = bm_r[0];
  assign last_pos = (pos_r == PW'(NUM_BLOCKS - 1));
  assign at_idx   = (32'(pos_r) == 32'(idx_r));
  assign in_range = (32'(pos_r) >= 32'(idx_r)) &&
                    (32'(pos_r) < (32'(idx_r) + 32'(cnt_r)));
  assign cur_sum  = cur_bytes_r + BW'(BLOCK_BYTES);

  always_comb begin
    state_nxt      = state_r;
    bm_nxt         = bm_r;
    pos_nxt        = pos_r;
    free_nxt       = free_r;
    cmd_nxt        = cmd_r;
    size_nxt       = size_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    start_nxt      = start_r;
    run_start_nxt  = run_start_r;
    cur_bytes_nxt  = cur_bytes_r;
    mark_bytes_nxt = mark_bytes_r;
    found_nxt      = found_r;
    prod_nxt       = prod_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    tr_clr         = 1'b0;
    tr_en          = 1'b0;
    tr_free        = 1'b0;
    new_b          = head;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_data.command;
          size_nxt       = in_data.size_bytes;
          idx_nxt        = in_data.block_index;
          cnt_nxt        = in_data.block_count;
          pos_nxt        = '0;
          start_nxt      = '0;
          mark_bytes_nxt = '0;
          status_nxt     = ffba_pkg::ST_OK;
          tr_clr         = 1'b1;
          state_nxt      = S_SCAN;
          case (in_data.command)
            ffba_pkg::CMD_ALLOC: begin
              if (in_data.size_bytes == '0) begin
                status_nxt = ffba_pkg::ST_BAD;
              end else begin
                prod_nxt  = PRW'(free_r) * PRW'(BLOCK_BYTES);
                state_nxt = S_CHECK;
              end
            end
            ffba_pkg::CMD_FREE, ffba_pkg::CMD_RANGE, ffba_pkg::CMD_CLAIM: begin
              if (32'(in_data.block_index) >= 32'(NUM_BLOCKS))
                status_nxt = ffba_pkg::ST_BAD;
            end
            ffba_pkg::CMD_CLEAR: begin
              free_nxt = CW'(NUM_BLOCKS);
            end
            default: begin
              status_nxt = ffba_pkg::ST_BAD;
            end
          endcase
        end
      end

      S_CHECK: begin
        cur_bytes_nxt = '0;
        run_start_nxt = '0;
        found_nxt     = 1'b0;
        pos_nxt       = '0;
        // free bytes below the request: not enough space overall
        if (32'(prod_r) < 32'(size_r)) begin
          status_nxt = ffba_pkg::ST_SHORT;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_FIND;
        end
      end

      S_FIND: begin
        bm_nxt = {head, bm_r[NUM_BLOCKS-1:1]};
        if (!found_r) begin
          if (!head) begin
            if (cur_sum >= BW'(size_r)) begin
              found_nxt = 1'b1;
              start_nxt = run_start_r;
            end else begin
              cur_bytes_nxt = cur_sum;
            end
          end else begin
            cur_bytes_nxt = '0;
            run_start_nxt = pos_r + PW'(1);
          end
        end
        pos_nxt = pos_r + PW'(1);
        if (last_pos) begin
          pos_nxt   = '0;
          state_nxt = S_SCAN;
          if (!found_nxt) status_nxt = ffba_pkg::ST_NORUN;
        end
      end

      S_SCAN: begin
        if (cmd_r == ffba_pkg::CMD_CLEAR) begin
          new_b = 1'b0;
        end else if (status_r == ffba_pkg::ST_OK) begin
          case (cmd_r)
            ffba_pkg::CMD_ALLOC: begin
              if (pos_r >= start_r && mark_bytes_r < BW'(size_r)) begin
                new_b          = 1'b1;
                mark_bytes_nxt = mark_bytes_r + BW'(BLOCK_BYTES);
                free_nxt       = free_r - CW'(1);
              end
            end
            ffba_pkg::CMD_FREE: begin
              if (at_idx) begin
                if (head) begin
                  new_b    = 1'b0;
                  free_nxt = free_r + CW'(1);
                end else begin
                  status_nxt = ffba_pkg::ST_NOTUSED;
                end
              end
            end
            ffba_pkg::CMD_RANGE: begin
              if (in_range && head) begin
                new_b    = 1'b0;
                free_nxt = free_r + CW'(1);
              end
            end
            ffba_pkg::CMD_CLAIM: begin
              if (at_idx) begin
                if (head) begin
                  status_nxt = ffba_pkg::ST_USED;
                end else begin
                  new_b    = 1'b1;
                  free_nxt = free_r - CW'(1);
                end
              end
            end
            default: begin
              new_b = head;
            end
          endcase
        end
        bm_nxt  = {new_b, bm_r[NUM_BLOCKS-1:1]};
        tr_en   = 1'b1;
        tr_free = !new_b;
        pos_nxt = pos_r + PW'(1);
        if (last_pos) begin
          pos_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.status           = status_r;
          out_data_nxt.start_block      =
            (cmd_r == ffba_pkg::CMD_ALLOC && status_r == ffba_pkg::ST_OK) ?
            ffba_pkg::INDEX_W'(start_r) : '0;
          out_data_nxt.free_blocks      = ffba_pkg::COUNT_W'(free_r);
          out_data_nxt.largest_free_run = ffba_pkg::COUNT_W'(best);
          out_valid_nxt                 = 1'b1;
          state_nxt                     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bm_r        <= '0;
      pos_r       <= '0;
      free_r      <= CW'(NUM_BLOCKS);
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bm_r        <= bm_nxt;
      pos_r       <= pos_nxt;
      free_r      <= free_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    size_r       <= size_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    start_r      <= start_nxt;
    run_start_r  <= run_start_nxt;
    cur_bytes_r  <= cur_bytes_nxt;
    mark_bytes_r <= mark_bytes_nxt;
    prod_r       <= prod_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // free count can never pass the pool size
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(NUM_BLOCKS))
    else $error("free counter above pool size");

  // a new result only ever comes out of the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside result state");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted item not started");

  // failed commands report a zero start block
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ffba_pkg::ST_OK) |->
      (out_data_r.start_block == '0))
    else $error("start block set on failed command");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
// A directed table covers reset state, the size extremes, every command and
// each error status. Random commands follow, biased toward sensible traffic
// with some noise. A bitmap model in the bench tracks every command and
// predicts each result that the table does not give. Both channel ends idle
// at random. The receiver holds off once for a long spell so that the block
// backs up. The sender pauses once until all results are in.
module tb;

  localparam int NB          = ffba_pkg::NUM_BLOCKS_DEF;
  localparam int BB          = ffba_pkg::BLOCK_BYTES_DEF;
  localparam int RANDOM_CMDS = 1225;
  localparam int DRAIN_AT    = 700;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 3000;
  localparam int CYCLE_LIMIT = 2500000;

  typedef struct {
    ffba_pkg::in_item_t  item;
    bit                  typed;
    ffba_pkg::out_item_t result;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ffba_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ffba_pkg::out_item_t out_data;

  // bitmap model
  bit [NB-1:0] model_used;
  int unsigned model_free;

  ffba_pkg::out_item_t pending_results[$];
  stim_row_t           directed[$];
  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;

  first_fit_block_bitmap_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned longest_free_run();
    int unsigned best;
    int unsigned cur;
    best = 0;
    cur  = 0;
    for (int i = 0; i < NB; i++) begin
      if (!model_used[i]) begin
        cur++;
        if (cur > best) best = cur;
      end else begin
        cur = 0;
      end
    end
    return best;
  endfunction

  // Applies one command to the model and returns the result it should give.
  function automatic ffba_pkg::out_item_t predict_command(ffba_pkg::in_item_t it);
    ffba_pkg::out_item_t res;
    int unsigned need;
    int unsigned cur;
    int unsigned first;
    int unsigned idx;
    int unsigned stop;
    bit          found;
    res   = '0;
    idx   = 32'(it.block_index);
    found = 1'b0;
    first = 0;
    res.status = ffba_pkg::ST_OK;
    case (it.command)
      ffba_pkg::CMD_ALLOC: begin
        if (it.size_bytes == 0) begin
          res.status = ffba_pkg::ST_BAD;
        end else begin
          need = (int'(it.size_bytes) + BB - 1) / BB;
          if (need > model_free) begin
            res.status = ffba_pkg::ST_SHORT;
          end else begin
            cur = 0;
            for (int i = 0; i < NB && !found; i++) begin
              if (!model_used[i]) begin
                cur++;
                if (cur >= need) begin
                  found = 1'b1;
                  first = i + 1 - cur;
                end
              end else begin
                cur = 0;
              end
            end
            if (!found) begin
              res.status = ffba_pkg::ST_NORUN;
            end else begin
              for (int i = 0; i < need; i++) model_used[first + i] = 1'b1;
              model_free -= need;
              res.start_block = ffba_pkg::INDEX_W'(first);
            end
          end
        end
      end
      ffba_pkg::CMD_FREE: begin
        if (idx >= NB) res.status = ffba_pkg::ST_BAD;
        else if (!model_used[idx]) res.status = ffba_pkg::ST_NOTUSED;
        else begin
          model_used[idx] = 1'b0;
          model_free++;
        end
      end
      ffba_pkg::CMD_RANGE: begin
        if (idx >= NB) begin
          res.status = ffba_pkg::ST_BAD;
        end else begin
          stop = idx + 32'(it.block_count);
          for (int i = int'(idx); i < stop && i < NB; i++) begin
            if (model_used[i]) begin
              model_used[i] = 1'b0;
              model_free++;
            end
          end
        end
      end
      ffba_pkg::CMD_CLAIM: begin
        if (idx >= NB) res.status = ffba_pkg::ST_BAD;
        else if (model_used[idx]) res.status = ffba_pkg::ST_USED;
        else begin
          model_used[idx] = 1'b1;
          model_free--;
        end
      end
      ffba_pkg::CMD_CLEAR: begin
        model_used = '0;
        model_free = NB;
      end
      default: res.status = ffba_pkg::ST_BAD;
    endcase
    res.free_blocks      = ffba_pkg::COUNT_W'(model_free);
    res.largest_free_run = ffba_pkg::COUNT_W'(longest_free_run());
    return res;
  endfunction

  function automatic void add_row(logic [ffba_pkg::CMD_W-1:0] cmd, int size, int idx,
                                  int cnt, bit typed,
                                  logic [ffba_pkg::STAT_W-1:0] st, int first,
                                  int fr, int run);
    stim_row_t row;
    row.item.command            = cmd;
    row.item.size_bytes         = ffba_pkg::SIZE_W'(size);
    row.item.block_index        = ffba_pkg::INDEX_W'(idx);
    row.item.block_count        = ffba_pkg::COUNT_W'(cnt);
    row.typed                   = typed;
    row.result.status           = st;
    row.result.start_block      = ffba_pkg::INDEX_W'(first);
    row.result.free_blocks      = ffba_pkg::COUNT_W'(fr);
    row.result.largest_free_run = ffba_pkg::COUNT_W'(run);
    directed.insert(directed.size(), row);
  endfunction

  function automatic int unsigned pick_used_block();
    int unsigned base;
    base = $urandom_range(0, NB - 1);
    for (int i = 0; i < NB; i++) begin
      if (model_used[(base + i) % NB]) return (base + i) % NB;
    end
    return base;
  endfunction

  // Mostly well-formed traffic; unused fields carry random bits throughout.
  function automatic ffba_pkg::in_item_t random_command();
    ffba_pkg::in_item_t it;
    int unsigned r;
    int unsigned s;
    it.command     = ffba_pkg::CMD_ALLOC;
    it.size_bytes  = ffba_pkg::SIZE_W'($urandom_range(0, 16384));
    it.block_index = ffba_pkg::INDEX_W'($urandom_range(0, NB - 1));
    it.block_count = ffba_pkg::COUNT_W'($urandom_range(0, NB));
    r = $urandom_range(0, 99);
    if (r < 37) begin
      it.command = ffba_pkg::CMD_ALLOC;
      s = $urandom_range(0, 99);
      if (s < 80) it.size_bytes = ffba_pkg::SIZE_W'($urandom_range(1, 1024));
      else if (s < 95) it.size_bytes = ffba_pkg::SIZE_W'($urandom_range(1025, 16384));
      else begin
        case ($urandom_range(0, 3))
          0: it.size_bytes = '0;
          1: it.size_bytes = ffba_pkg::SIZE_W'(16384);
          2: it.size_bytes = ffba_pkg::SIZE_W'(BB * $urandom_range(1, 16));
          default: it.size_bytes = ffba_pkg::SIZE_W'(BB * $urandom_range(1, 16) + 1);
        endcase
      end
    end else if (r < 57) begin
      it.command = ffba_pkg::CMD_FREE;
      if ($urandom_range(0, 4) != 0)
        it.block_index = ffba_pkg::INDEX_W'(pick_used_block());
    end else if (r < 69) begin
      it.command = ffba_pkg::CMD_CLAIM;
    end else if (r < 81) begin
      it.command = ffba_pkg::CMD_RANGE;
      if ($urandom_range(0, 3) != 0)
        it.block_count = ffba_pkg::COUNT_W'($urandom_range(0, 32));
    end else if (r < 84) begin
      it.command = ffba_pkg::CMD_CLEAR;
    end else begin
      it.command = ffba_pkg::CMD_W'($urandom_range(0, 7));
    end
    return it;
  endfunction

  // No-idle stretches every fourth hundred items.
  function automatic int unsigned draw_gap();
    if ((items_sent / 100) % 4 == 3) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic int unsigned draw_hold();
    if (results_seen == HOLD_AT) return HOLD_LEN;
    if ((results_seen / 150) % 3 == 2) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_item(input ffba_pkg::in_item_t it, input bit typed,
                           input ffba_pkg::out_item_t typed_res, input bit drain);
    int unsigned         gap;
    ffba_pkg::out_item_t predicted;
    gap = draw_gap();
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      if (drain) begin
        while (pending_results.size() != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_command(it);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic check_result(input ffba_pkg::out_item_t got);
    ffba_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
    end
    if (got.start_block !== want.start_block) begin
      errors++;
      $display("%0t: start_block expected %0d actual %0d", $time,
               want.start_block, got.start_block);
    end
    if (got.free_blocks !== want.free_blocks) begin
      errors++;
      $display("%0t: free_blocks expected %0d actual %0d", $time,
               want.free_blocks, got.free_blocks);
    end
    if (got.largest_free_run !== want.largest_free_run) begin
      errors++;
      $display("%0t: largest_free_run expected %0d actual %0d", $time,
               want.largest_free_run, got.largest_free_run);
    end
  endtask

  // result side
  initial begin
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result(out_data);
        results_seen++;
        hold = draw_hold();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    model_used = '0;
    model_free = NB;

    add_row(ffba_pkg::CMD_FREE,  0,     5,   0,   1, ffba_pkg::ST_NOTUSED, 0, 256, 256);
    add_row(ffba_pkg::CMD_CLAIM, 0,     255, 0,   1, ffba_pkg::ST_OK,      0, 255, 255);
    add_row(ffba_pkg::CMD_FREE,  0,     255, 0,   1, ffba_pkg::ST_OK,      0, 256, 256);
    add_row(ffba_pkg::CMD_ALLOC, 0,     0,   0,   1, ffba_pkg::ST_BAD,     0, 256, 256);
    add_row(ffba_pkg::CMD_ALLOC, 1,     0,   0,   1, ffba_pkg::ST_OK,      0, 255, 255);
    add_row(ffba_pkg::CMD_ALLOC, 65,    0,   0,   1, ffba_pkg::ST_OK,      1, 253, 253);
    add_row(ffba_pkg::CMD_CLEAR, 0,     0,   0,   1, ffba_pkg::ST_OK,      0, 256, 256);
    add_row(ffba_pkg::CMD_ALLOC, 16384, 0,   0,   1, ffba_pkg::ST_OK,      0, 0,   0);
    add_row(ffba_pkg::CMD_ALLOC, 1,     0,   0,   1, ffba_pkg::ST_SHORT,   0, 0,   0);
    add_row(ffba_pkg::CMD_CLAIM, 0,     0,   0,   1, ffba_pkg::ST_USED,    0, 0,   0);
    add_row(ffba_pkg::CMD_FREE,  0,     10,  0,   1, ffba_pkg::ST_OK,      0, 1,   1);
    add_row(ffba_pkg::CMD_FREE,  0,     20,  0,   1, ffba_pkg::ST_OK,      0, 2,   1);
    // two free blocks, but not adjacent
    add_row(ffba_pkg::CMD_ALLOC, 128,   0,   0,   1, ffba_pkg::ST_NORUN,   0, 2,   1);
    add_row(ffba_pkg::CMD_RANGE, 0,     30,  0,   1, ffba_pkg::ST_OK,      0, 2,   1);
    // clipped at the last block: 250..255 come free
    add_row(ffba_pkg::CMD_RANGE, 0,     250, 256, 1, ffba_pkg::ST_OK,      0, 8,   6);
    add_row(3'd5,                0,     0,   0,   1, ffba_pkg::ST_BAD,     0, 8,   6);
    add_row(3'd6,                1,     1,   1,   1, ffba_pkg::ST_BAD,     0, 8,   6);
    add_row(3'd7,                32767, 255, 511, 1, ffba_pkg::ST_BAD,     0, 8,   6);
    add_row(ffba_pkg::CMD_ALLOC, 16383, 0,   0,   1, ffba_pkg::ST_SHORT,   0, 8,   6);
    add_row(ffba_pkg::CMD_ALLOC, 384,   0,   0,   0, ffba_pkg::ST_OK,      0, 0,   0);
    add_row(ffba_pkg::CMD_CLAIM, 0,     252, 0,   0, ffba_pkg::ST_OK,      0, 0,   0);
    add_row(ffba_pkg::CMD_RANGE, 0,     0,   256, 1, ffba_pkg::ST_OK,      0, 256, 256);
    add_row(ffba_pkg::CMD_ALLOC, 16320, 0,   0,   1, ffba_pkg::ST_OK,      0, 1,   1);
    add_row(ffba_pkg::CMD_RANGE, 0,     100, 37,  0, ffba_pkg::ST_OK,      0, 0,   0);
    add_row(ffba_pkg::CMD_CLEAR, 0,     0,   0,   0, ffba_pkg::ST_OK,      0, 0,   0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].result, 0);
    for (int n = 0; n < RANDOM_CMDS; n++) send_item(random_command(), 0, '0, n == DRAIN_AT);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NB + 8) @(posedge clk);

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
